// ===== hw/rtl/plpc_pkg.sv =====
// shared types, codes and constants for the point light pool cull unit
package plpc_pkg;

    // number of light slots in the pool
    localparam int POOL_DEPTH = 32;

    // field widths of one transfer
    localparam int IDX_W      = 5;
    localparam int POS_W      = 24;
    localparam int COLOR_W    = 32;
    localparam int RAD_W      = 23;
    localparam int CNT_W      = 6;
    localparam int TDATA_W    = 144;
    localparam int IN_USER_W  = 3;
    localparam int OUT_USER_W = 2;

    // smallest radius given to an added light: 0.1 in Q15.8, rounded
    localparam logic [RAD_W-1:0] MIN_RADIUS = 23'd26;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_WRITE  = 3'd1,
        OP_READ   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_SET_EN = 3'd4,
        OP_QUERY  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_NONE      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APPLY,
        S_EMIT,
        S_Q_CHECK,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_SQ,
        S_Q_CMP,
        S_Q_EMIT,
        S_Q_TAKE,
        S_Q_FINAL
    } state_t;

    typedef enum logic [1:0] {RA_IDX, RA_LAST, RA_WALK} rd_sel_t;
    typedef enum logic {WA_IDX, WA_COUNT} wa_sel_t;
    typedef enum logic [2:0] {WS_NONE, WS_INPUT, WS_ADD, WS_RDATA, WS_RDATA_EN} work_src_t;
    typedef enum logic [1:0] {IS_NONE, IS_IN, IS_COUNT, IS_WALK} idx_src_t;
    typedef enum logic [1:0] {OI_HELD, OI_ONES, OI_ZERO} out_idx_t;

    // input fields, last declared sits in the lowest bits of tdata
    typedef struct packed {
        logic [CNT_W-1:0]   max_count;
        logic               enable_flag;
        logic [RAD_W-1:0]   radius_in;
        logic [COLOR_W-1:0] color_rgba;
        logic [POS_W-1:0]   pos_z;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pos_x;
        logic [IDX_W-1:0]   light_index;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   z;
        logic [COLOR_W-1:0] color;
        logic [RAD_W-1:0]   radius;
        logic               enabled;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic      latch_in;
        logic      mem_rd;
        rd_sel_t   rd_sel;
        logic      mem_wr;
        wa_sel_t   wa_sel;
        work_src_t work_src;
        idx_src_t  idx_src;
        logic      count_inc;
        logic      count_dec;
        logic      walk_clr;
        logic      walk_inc;
        logic      match_inc;
        logic      out_load;
        status_t   out_status;
        out_idx_t  out_idx;
        logic      out_entry;
        logic      out_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic idx_valid;
        logic full;
        logic walk_done;
        logic have_match;
        logic hit;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/point_light_pool_cull_unit.sv =====
// Point light pool with distance culling query.
// One input transfer carries an op (tuser) and its operands (tdata); each op
// returns one result transfer; a query returns one per matching light, up to
// max_count, or one none result if none match; tlast marks the last. Ops:
// add, write, read, remove, set enable, query. An input is taken only while
// the sequencer is idle; a finished result waits in the output register while
// the next input is taken. Add and write give their result from the decode
// state; a valid read, remove or set enable passes through an apply state
// first. A query walks the stored lights one at a time through the store read
// port and the distance pipeline (check, read, wait, square, compare); a match
// adds a take step and each match after the first an emit step, in which the
// held match goes out while the walk waits; a final check and result close it.
// Reset empties the pool; stored light data is not cleared.
// When the receiver stalls, results hold in the output register and the walk
// pauses until a result transfer frees it.
module point_light_pool_cull_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // light_index, pos_x, pos_y, pos_z, color_rgba, radius_in, enable_flag, max_count
    input  logic [143:0] s_axis_tdata,
    // op
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_index, out_pos_x, out_pos_y, out_pos_z, out_color, out_radius,
    // out_enabled, out_count
    output logic [143:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    plpc_pkg::dp_cmd_t  cmd;
    plpc_pkg::dp_stat_t stat;

    plpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plpc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // a result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending transfer");

    // the store is never written while an input can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> !s_axis_tready)
        else $error("store write while idle");

    // one input at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while busy");
`endif

endmodule

// ===== hw/rtl/plpc_datapath.sv =====
// light store, query distance pipeline and output register
module plpc_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  plpc_pkg::dp_cmd_t                cmd,
    output plpc_pkg::dp_stat_t               stat,
    input  logic [plpc_pkg::TDATA_W-1:0]     in_data,
    input  logic [plpc_pkg::IN_USER_W-1:0]   in_user,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [plpc_pkg::TDATA_W-1:0]     out_data,
    output logic [plpc_pkg::OUT_USER_W-1:0]  out_user,
    output logic                             out_last
);

    localparam int AW = (plpc_pkg::POOL_DEPTH > 1) ? $clog2(plpc_pkg::POOL_DEPTH) : 1;
    localparam int CW = $clog2(plpc_pkg::POOL_DEPTH + 1);

    plpc_pkg::op_t      op_reg;
    plpc_pkg::in_item_t in_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      walk_reg, walk_next;
    logic [CW-1:0]      match_reg, match_next;
    plpc_pkg::entry_t   work_reg, work_next;
    logic [4:0]         res_idx_reg, res_idx_next;
    plpc_pkg::entry_t   rdata_reg;
    plpc_pkg::entry_t   mem [plpc_pkg::POOL_DEPTH];
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [22:0]        add_radius;

    logic [23:0] dx_reg, dy_reg, dz_reg, reach_reg;
    logic [47:0] sqx_reg, sqy_reg, sqz_reg, sqr_reg;
    logic [47:0] sqx_next, sqy_next, sqz_next, sqr_next;
    logic [49:0] dist_sum;

    logic                                out_valid_reg;
    logic [plpc_pkg::TDATA_W-1:0]        out_data_reg, out_data_next;
    logic [plpc_pkg::OUT_USER_W-1:0]     out_user_reg;
    logic                                out_last_reg;
    logic [4:0]                          oidx;
    plpc_pkg::entry_t                    oent;

    // magnitude of the difference of two signed Q15.8 values
    function automatic logic [23:0] abs_diff(input logic [23:0] a, input logic [23:0] b);
        logic [24:0] d;
        logic [24:0] m;
        d = {a[23], a} - {b[23], b};
        m = d[24] ? (~d + 25'd1) : d;
        return m[23:0];
    endfunction

    // input transfer capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_reg <= plpc_pkg::in_item_t'(in_data[138:0]);
            op_reg <= plpc_pkg::op_t'(in_user);
        end
    end

    // status for the controller
    assign stat.op         = op_reg;
    assign stat.idx_valid  = 8'(in_reg.light_index) < 8'(count_reg);
    assign stat.full       = count_reg == CW'(plpc_pkg::POOL_DEPTH);
    assign stat.walk_done  = (8'(walk_reg) >= 8'(count_reg))
                           || (8'(match_reg) >= 8'(in_reg.max_count));
    assign stat.have_match = match_reg != '0;
    assign stat.hit        = rdata_reg.enabled && (dist_sum <= {2'b00, sqr_reg});
    assign stat.out_free   = !out_valid_reg || out_ready;

    // address selection
    always_comb
    begin
        case (cmd.rd_sel)
            plpc_pkg::RA_IDX:  rd_addr = AW'(in_reg.light_index);
            plpc_pkg::RA_LAST: rd_addr = AW'(count_reg - 1'b1);
            plpc_pkg::RA_WALK: rd_addr = AW'(walk_reg);
            default:           rd_addr = AW'(walk_reg);
        endcase
        wr_addr = (cmd.wa_sel == plpc_pkg::WA_COUNT) ? AW'(count_reg)
                                                      : AW'(in_reg.light_index);
    end

    // working entry source, also the store write data
    assign add_radius = (in_reg.radius_in < plpc_pkg::MIN_RADIUS) ? plpc_pkg::MIN_RADIUS
                                                                   : in_reg.radius_in;
    always_comb
    begin
        case (cmd.work_src)
            plpc_pkg::WS_INPUT:
                work_next = '{in_reg.pos_x, in_reg.pos_y, in_reg.pos_z, in_reg.color_rgba,
                              in_reg.radius_in, in_reg.enable_flag};
            plpc_pkg::WS_ADD:
                work_next = '{in_reg.pos_x, in_reg.pos_y, in_reg.pos_z, in_reg.color_rgba,
                              add_radius, 1'b1};
            plpc_pkg::WS_RDATA:
                work_next = rdata_reg;
            plpc_pkg::WS_RDATA_EN:
                work_next = '{rdata_reg.x, rdata_reg.y, rdata_reg.z, rdata_reg.color,
                              rdata_reg.radius, in_reg.enable_flag};
            default:
                work_next = work_reg;
        endcase
    end

    // light store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= work_next;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
        work_reg    <= work_next;
        res_idx_reg <= res_idx_next;
    end

    // held result index
    always_comb
    begin
        case (cmd.idx_src)
            plpc_pkg::IS_IN:    res_idx_next = in_reg.light_index;
            plpc_pkg::IS_COUNT: res_idx_next = 5'(count_reg);
            plpc_pkg::IS_WALK:  res_idx_next = 5'(walk_reg);
            default:            res_idx_next = res_idx_reg;
        endcase
    end

    // counters
    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end
        walk_next  = cmd.walk_clr ? '0 : (cmd.walk_inc ? walk_reg + 1'b1 : walk_reg);
        match_next = cmd.walk_clr ? '0 : (cmd.match_inc ? match_reg + 1'b1 : match_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            walk_reg  <= '0;
            match_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            walk_reg  <= walk_next;
            match_reg <= match_next;
        end
    end

    // distance pipeline: differences, then squares, then sum and compare
    assign sqx_next = dx_reg * dx_reg;
    assign sqy_next = dy_reg * dy_reg;
    assign sqz_next = dz_reg * dz_reg;
    assign sqr_next = reach_reg * reach_reg;
    assign dist_sum = 50'(sqx_reg) + 50'(sqy_reg) + 50'(sqz_reg);

    always_ff @(posedge clk)
    begin
        dx_reg    <= abs_diff(rdata_reg.x, in_reg.pos_x);
        dy_reg    <= abs_diff(rdata_reg.y, in_reg.pos_y);
        dz_reg    <= abs_diff(rdata_reg.z, in_reg.pos_z);
        reach_reg <= {1'b0, in_reg.radius_in} + {1'b0, rdata_reg.radius};
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        sqz_reg   <= sqz_next;
        sqr_reg   <= sqr_next;
    end

    // result assembly
    always_comb
    begin
        case (cmd.out_idx)
            plpc_pkg::OI_HELD: oidx = res_idx_reg;
            plpc_pkg::OI_ONES: oidx = '1;
            default:           oidx = '0;
        endcase
        oent = cmd.out_entry ? work_reg : '0;
        out_data_next = {5'd0, 6'(count_reg), oent.enabled, oent.radius, oent.color,
                         oent.z, oent.y, oent.x, oidx};
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= cmd.out_status;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hw/rtl/plpc_ctrl.sv =====
// operation sequencer for the point light pool cull unit
module plpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  plpc_pkg::dp_stat_t  stat,
    output plpc_pkg::dp_cmd_t   cmd
);

    plpc_pkg::state_t   state_reg, state_next;
    plpc_pkg::status_t  res_status_reg, res_status_next;
    plpc_pkg::out_idx_t res_idx_sel_reg, res_idx_sel_next;
    logic               res_entry_reg, res_entry_next;

    // state and result descriptor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= plpc_pkg::S_IDLE;
            res_status_reg  <= plpc_pkg::STAT_OK;
            res_idx_sel_reg <= plpc_pkg::OI_HELD;
            res_entry_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            res_status_reg  <= res_status_next;
            res_idx_sel_reg <= res_idx_sel_next;
            res_entry_reg   <= res_entry_next;
        end
    end

    // next state
    always_comb
    begin
        state_next       = state_reg;
        res_status_next  = res_status_reg;
        res_idx_sel_next = res_idx_sel_reg;
        res_entry_next   = res_entry_reg;
        unique case (state_reg)
            plpc_pkg::S_IDLE:
                if (in_valid)
                begin
                    state_next = plpc_pkg::S_DECODE;
                end
            plpc_pkg::S_DECODE:
            begin
                state_next       = plpc_pkg::S_EMIT;
                res_status_next  = plpc_pkg::STAT_BAD_INDEX;
                res_idx_sel_next = plpc_pkg::OI_HELD;
                res_entry_next   = 1'b0;
                case (stat.op) inside
                    plpc_pkg::OP_ADD:
                        if (stat.full)
                        begin
                            res_status_next  = plpc_pkg::STAT_FULL;
                            res_idx_sel_next = plpc_pkg::OI_ONES;
                        end
                        else
                        begin
                            res_status_next = plpc_pkg::STAT_OK;
                            res_entry_next  = 1'b1;
                        end
                    plpc_pkg::OP_WRITE:
                        if (stat.idx_valid)
                        begin
                            res_status_next = plpc_pkg::STAT_OK;
                            res_entry_next  = 1'b1;
                        end
                    plpc_pkg::OP_READ, plpc_pkg::OP_SET_EN:
                        if (stat.idx_valid)
                        begin
                            res_status_next = plpc_pkg::STAT_OK;
                            res_entry_next  = 1'b1;
                            state_next      = plpc_pkg::S_APPLY;
                        end
                    plpc_pkg::OP_REMOVE:
                        if (stat.idx_valid)
                        begin
                            res_status_next = plpc_pkg::STAT_OK;
                            state_next      = plpc_pkg::S_APPLY;
                        end
                    plpc_pkg::OP_QUERY:
                        state_next = plpc_pkg::S_Q_CHECK;
                    default:
                        res_idx_sel_next = plpc_pkg::OI_ZERO;
                endcase
            end
            plpc_pkg::S_APPLY:
                state_next = plpc_pkg::S_EMIT;
            plpc_pkg::S_EMIT:
                if (stat.out_free)
                begin
                    state_next = plpc_pkg::S_IDLE;
                end
            plpc_pkg::S_Q_CHECK:
                state_next = stat.walk_done ? plpc_pkg::S_Q_FINAL : plpc_pkg::S_Q_RD;
            plpc_pkg::S_Q_RD:
                state_next = plpc_pkg::S_Q_WAIT;
            plpc_pkg::S_Q_WAIT:
                state_next = plpc_pkg::S_Q_SQ;
            plpc_pkg::S_Q_SQ:
                state_next = plpc_pkg::S_Q_CMP;
            plpc_pkg::S_Q_CMP:
                if (!stat.hit)
                begin
                    state_next = plpc_pkg::S_Q_CHECK;
                end
                else if (stat.have_match)
                begin
                    state_next = plpc_pkg::S_Q_EMIT;
                end
                else
                begin
                    state_next = plpc_pkg::S_Q_TAKE;
                end
            plpc_pkg::S_Q_EMIT:
                if (stat.out_free)
                begin
                    state_next = plpc_pkg::S_Q_TAKE;
                end
            plpc_pkg::S_Q_TAKE:
                state_next = plpc_pkg::S_Q_CHECK;
            plpc_pkg::S_Q_FINAL:
                if (stat.out_free)
                begin
                    state_next = plpc_pkg::S_IDLE;
                end
            default:
                state_next = plpc_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = plpc_pkg::RA_IDX;
        cmd.wa_sel     = plpc_pkg::WA_IDX;
        cmd.work_src   = plpc_pkg::WS_NONE;
        cmd.idx_src    = plpc_pkg::IS_NONE;
        cmd.out_status = plpc_pkg::STAT_OK;
        cmd.out_idx    = plpc_pkg::OI_HELD;
        in_ready       = 1'b0;
        unique case (state_reg)
            plpc_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            plpc_pkg::S_DECODE:
            begin
                cmd.idx_src = plpc_pkg::IS_IN;
                case (stat.op) inside
                    plpc_pkg::OP_ADD:
                        if (!stat.full)
                        begin
                            cmd.mem_wr    = 1'b1;
                            cmd.wa_sel    = plpc_pkg::WA_COUNT;
                            cmd.work_src  = plpc_pkg::WS_ADD;
                            cmd.idx_src   = plpc_pkg::IS_COUNT;
                            cmd.count_inc = 1'b1;
                        end
                    plpc_pkg::OP_WRITE:
                        if (stat.idx_valid)
                        begin
                            cmd.mem_wr   = 1'b1;
                            cmd.work_src = plpc_pkg::WS_INPUT;
                        end
                    plpc_pkg::OP_READ, plpc_pkg::OP_SET_EN:
                        cmd.mem_rd = stat.idx_valid;
                    plpc_pkg::OP_REMOVE:
                    begin
                        cmd.mem_rd = stat.idx_valid;
                        cmd.rd_sel = plpc_pkg::RA_LAST;
                    end
                    plpc_pkg::OP_QUERY:
                        cmd.walk_clr = 1'b1;
                    default:
                        cmd.walk_clr = 1'b0;
                endcase
            end
            plpc_pkg::S_APPLY:
                case (stat.op) inside
                    plpc_pkg::OP_SET_EN:
                    begin
                        cmd.mem_wr   = 1'b1;
                        cmd.work_src = plpc_pkg::WS_RDATA_EN;
                    end
                    plpc_pkg::OP_REMOVE:
                    begin
                        // last entry moves into the freed slot
                        cmd.mem_wr    = 1'b1;
                        cmd.work_src  = plpc_pkg::WS_RDATA;
                        cmd.count_dec = 1'b1;
                    end
                    default:
                        cmd.work_src = plpc_pkg::WS_RDATA;
                endcase
            plpc_pkg::S_EMIT:
            begin
                cmd.out_load   = stat.out_free;
                cmd.out_status = res_status_reg;
                cmd.out_idx    = res_idx_sel_reg;
                cmd.out_entry  = res_entry_reg;
                cmd.out_last   = 1'b1;
            end
            plpc_pkg::S_Q_RD:
            begin
                cmd.mem_rd = 1'b1;
                cmd.rd_sel = plpc_pkg::RA_WALK;
            end
            plpc_pkg::S_Q_CMP:
                cmd.walk_inc = !stat.hit;
            plpc_pkg::S_Q_EMIT:
            begin
                // the held match is not the last one
                cmd.out_load  = stat.out_free;
                cmd.out_entry = 1'b1;
            end
            plpc_pkg::S_Q_TAKE:
            begin
                cmd.work_src  = plpc_pkg::WS_RDATA;
                cmd.idx_src   = plpc_pkg::IS_WALK;
                cmd.match_inc = 1'b1;
                cmd.walk_inc  = 1'b1;
            end
            plpc_pkg::S_Q_FINAL:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_last = 1'b1;
                if (stat.have_match)
                begin
                    cmd.out_entry = 1'b1;
                end
                else
                begin
                    cmd.out_status = plpc_pkg::STAT_NONE;
                    cmd.out_idx    = plpc_pkg::OI_ZERO;
                end
            end
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule
